### hw/rtl/range_state_boundary_map_top_macros.svh
// assertion macros for the range state boundary map
// used by range_state_boundary_map_top, no other dependencies
`ifndef RANGE_STATE_BOUNDARY_MAP_TOP_MACROS_SVH
`define RANGE_STATE_BOUNDARY_MAP_TOP_MACROS_SVH

// same-cycle implication
`define RSBM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RSBM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hw/rtl/rsbm_pkg.sv
// shared types and constants for the range state boundary map
// no dependencies
package rsbm_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int ADDR_BITS_DEF = 48;
    localparam int FIELD_AW      = 48;
    localparam int STATE_W       = 16;
    localparam int IDX_W         = 6;
    localparam int COUNT_W       = 7;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_EMPTY     = 2'd1,
        STATUS_FULL      = 2'd2,
        STATUS_BAD_INDEX = 2'd3
    } status_t;

    typedef enum logic {
        OP_PAINT = 1'b0,
        OP_READ  = 1'b1
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_PLAN,
        ST_COPY_RD,
        ST_COPY_WR,
        ST_INS_A,
        ST_INS_B,
        ST_DONE
    } fsm_t;

    typedef struct packed {
        op_t                  operation;
        logic [FIELD_AW-1:0]  range_start;
        logic [FIELD_AW-1:0]  range_end;
        logic [STATE_W-1:0]   new_state;
        logic [IDX_W-1:0]     entry_index;
    } req_t;

    typedef struct packed {
        status_t              status;
        logic [COUNT_W-1:0]   boundary_count;
        logic [FIELD_AW-1:0]  entry_address;
        logic [STATE_W-1:0]   entry_state_in;
        logic [STATE_W-1:0]   entry_state_out;
    } rsp_t;

endpackage

### hw/rtl/rsbm_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module rsbm_ram #(
    parameter int WIDTH = 80,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/range_state_boundary_map_top.sv
// read: accept drives the ram address, ST_RD_WAIT takes the entry, ST_DONE loads the result;
// paint: scan read/check per boundary, plan, copy read/write per one moved, ST_INS_A/B, ST_DONE.
// one item at a time: the single ram read port and the scan/move sequencer set the rate.
// a new beat is accepted while the previous result still waits on the output register.
// reset clears the state, the response valid and the boundary count; ram entries are never read above the count.
// top level of the range state boundary map; uses rsbm_pkg, rsbm_ram and the macros header
`include "range_state_boundary_map_top_macros.svh"
module range_state_boundary_map_top #(
    parameter int ENTRIES   = rsbm_pkg::ENTRIES_DEF,
    parameter int ADDR_BITS = rsbm_pkg::ADDR_BITS_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  rsbm_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output rsbm_pkg::rsp_t rsp
);

    localparam int AW = (ADDR_BITS < rsbm_pkg::FIELD_AW) ? ADDR_BITS : rsbm_pkg::FIELD_AW;
    localparam int SW = rsbm_pkg::STATE_W;
    localparam int IW = $clog2(ENTRIES);
    localparam int KW = $clog2(ENTRIES + 3);
    localparam int XW = (IW > rsbm_pkg::IDX_W) ? IW : rsbm_pkg::IDX_W;
    localparam int WW = AW + 2 * SW;

    rsbm_pkg::fsm_t    state_reg, state_next;
    rsbm_pkg::op_t     op_reg, op_next;
    rsbm_pkg::status_t status_reg, status_next;
    logic [AW-1:0]     a_reg, a_next, b_reg, b_next;
    logic [SW-1:0]     s_reg, s_next;
    logic [XW-1:0]     idx_reg, idx_next;
    logic [KW-1:0]     count_reg, count_next;
    logic [KW-1:0]     i_reg, i_next;
    logic [KW-1:0]     p_reg, p_next, q_reg, q_next;
    logic [SW-1:0]     a_in_reg, a_in_next, b_out_reg, b_out_next;
    logic [KW-1:0]     src_reg, src_next, dst_reg, dst_next;
    logic [KW-1:0]     left_reg, left_next, k_reg, k_next;
    logic              up_reg, up_next;
    logic [WW-1:0]     ent_reg, ent_next;
    rsbm_pkg::rsp_t    rsp_reg, rsp_next;
    logic              rsp_valid_reg, rsp_valid_next;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr, ram_raddr;
    logic [WW-1:0]     ram_wdata, ram_rdata;

    logic [AW-1:0]     rd_addr;
    logic [SW-1:0]     rd_before, rd_after;
    logic [XW-1:0]     req_idx;
    logic              idx_ok;
    logic              ins_a, ins_b;
    logic [KW-1:0]     base, tail, k_new;

    rsbm_ram #(
        .WIDTH (WW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_addr   = ram_rdata[WW-1 -: AW];
    assign rd_before = ram_rdata[2*SW-1 -: SW];
    assign rd_after  = ram_rdata[SW-1:0];
    assign req_idx   = XW'(req.entry_index);
    assign idx_ok    = ({{KW{1'b0}}, req_idx} < {{XW{1'b0}}, count_reg});
    assign ins_a     = (a_in_reg != s_reg);
    assign ins_b     = (b_out_reg != s_reg);
    assign base      = p_reg + KW'(ins_a) + KW'(ins_b);
    assign tail      = count_reg - q_reg;
    assign k_new     = base + tail;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rsbm_pkg::ST_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        status_reg <= status_next;
        a_reg      <= a_next;
        b_reg      <= b_next;
        s_reg      <= s_next;
        idx_reg    <= idx_next;
        i_reg      <= i_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        a_in_reg   <= a_in_next;
        b_out_reg  <= b_out_next;
        src_reg    <= src_next;
        dst_reg    <= dst_next;
        left_reg   <= left_next;
        k_reg      <= k_next;
        up_reg     <= up_next;
        ent_reg    <= ent_next;
        rsp_reg    <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        status_next    = status_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        s_next         = s_reg;
        idx_next       = idx_reg;
        count_next     = count_reg;
        i_next         = i_reg;
        p_next         = p_reg;
        q_next         = q_reg;
        a_in_next      = a_in_reg;
        b_out_next     = b_out_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        left_next      = left_reg;
        k_next         = k_reg;
        up_next        = up_reg;
        ent_next       = ent_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        ram_we         = 1'b0;
        ram_waddr      = '0;
        ram_wdata      = '0;
        ram_raddr      = i_reg[IW-1:0];
        req_stall      = (state_reg != rsbm_pkg::ST_IDLE);

        unique case (state_reg)
            rsbm_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.operation;
                    a_next     = req.range_start[AW-1:0];
                    b_next     = req.range_end[AW-1:0];
                    s_next     = req.new_state;
                    idx_next   = req_idx;
                    ent_next   = '0;
                    i_next     = '0;
                    p_next     = '0;
                    q_next     = '0;
                    a_in_next  = '0;
                    b_out_next = '0;
                    if (req.operation == rsbm_pkg::OP_READ)
                    begin
                        if (idx_ok)
                        begin
                            ram_raddr   = req_idx[IW-1:0];
                            status_next = rsbm_pkg::STATUS_OK;
                            state_next  = rsbm_pkg::ST_RD_WAIT;
                        end
                        else
                        begin
                            status_next = rsbm_pkg::STATUS_BAD_INDEX;
                            state_next  = rsbm_pkg::ST_DONE;
                        end
                    end
                    else if (req.range_end[AW-1:0] <= req.range_start[AW-1:0])
                    begin
                        status_next = rsbm_pkg::STATUS_EMPTY;
                        state_next  = rsbm_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = rsbm_pkg::ST_SCAN_RD;
                    end
                end
            end
            rsbm_pkg::ST_RD_WAIT:
            begin
                ent_next   = ram_rdata;
                state_next = rsbm_pkg::ST_DONE;
            end
            rsbm_pkg::ST_SCAN_RD:
            begin
                if (i_reg == count_reg)
                begin
                    state_next = rsbm_pkg::ST_PLAN;
                end
                else
                begin
                    ram_raddr  = i_reg[IW-1:0];
                    state_next = rsbm_pkg::ST_SCAN_CHK;
                end
            end
            rsbm_pkg::ST_SCAN_CHK:
            begin
                // prefix below start, incoming state at start, last state at or below end
                if (rd_addr < a_reg)
                begin
                    p_next    = i_reg + 1'b1;
                    a_in_next = rd_after;
                end
                else if (rd_addr == a_reg)
                begin
                    a_in_next = rd_before;
                end
                if (rd_addr <= b_reg)
                begin
                    q_next     = i_reg + 1'b1;
                    b_out_next = rd_after;
                end
                i_next     = i_reg + 1'b1;
                state_next = rsbm_pkg::ST_SCAN_RD;
            end
            rsbm_pkg::ST_PLAN:
            begin
                if (k_new > KW'(ENTRIES))
                begin
                    status_next = rsbm_pkg::STATUS_FULL;
                    state_next  = rsbm_pkg::ST_DONE;
                end
                else
                begin
                    status_next = rsbm_pkg::STATUS_OK;
                    k_next      = k_new;
                    left_next   = tail;
                    if (tail == '0 || base == q_reg)
                    begin
                        state_next = rsbm_pkg::ST_INS_A;
                    end
                    else
                    begin
                        // moving up goes top down so no entry is overwritten before it is read
                        up_next    = (base > q_reg);
                        src_next   = (base > q_reg) ? count_reg - 1'b1 : q_reg;
                        dst_next   = (base > q_reg) ? k_new - 1'b1 : base;
                        state_next = rsbm_pkg::ST_COPY_RD;
                    end
                end
            end
            rsbm_pkg::ST_COPY_RD:
            begin
                ram_raddr  = src_reg[IW-1:0];
                state_next = rsbm_pkg::ST_COPY_WR;
            end
            rsbm_pkg::ST_COPY_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = dst_reg[IW-1:0];
                ram_wdata = ram_rdata;
                left_next = left_reg - 1'b1;
                src_next  = up_reg ? src_reg - 1'b1 : src_reg + 1'b1;
                dst_next  = up_reg ? dst_reg - 1'b1 : dst_reg + 1'b1;
                state_next = (left_reg == KW'(1)) ? rsbm_pkg::ST_INS_A : rsbm_pkg::ST_COPY_RD;
            end
            rsbm_pkg::ST_INS_A:
            begin
                if (ins_a)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = p_reg[IW-1:0];
                    ram_wdata = {a_reg, a_in_reg, s_reg};
                end
                state_next = rsbm_pkg::ST_INS_B;
            end
            rsbm_pkg::ST_INS_B:
            begin
                if (ins_b)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = IW'(p_reg + KW'(ins_a));
                    ram_wdata = {b_reg, s_reg, b_out_reg};
                end
                count_next = k_reg;
                state_next = rsbm_pkg::ST_DONE;
            end
            rsbm_pkg::ST_DONE:
            begin
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    rsp_next.status          = status_reg;
                    rsp_next.boundary_count  = rsbm_pkg::COUNT_W'(count_reg);
                    rsp_next.entry_address   = rsbm_pkg::FIELD_AW'(ent_reg[WW-1 -: AW]);
                    rsp_next.entry_state_in  = ent_reg[2*SW-1 -: SW];
                    rsp_next.entry_state_out = ent_reg[SW-1:0];
                    rsp_valid_next           = 1'b1;
                    state_next               = rsbm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rsbm_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `RSBM_ASSERT_IMP(a_count_bound, clk, rst_n, 1'b1, count_reg <= KW'(ENTRIES), "count above table size")
    `RSBM_ASSERT_NXT(a_idle_count, clk, rst_n, state_reg == rsbm_pkg::ST_IDLE, count_reg == $past(count_reg), "count changed while idle")
    `RSBM_ASSERT_IMP(a_we_state, clk, rst_n, ram_we, (state_reg == rsbm_pkg::ST_COPY_WR) || (state_reg == rsbm_pkg::ST_INS_A) || (state_reg == rsbm_pkg::ST_INS_B), "ram write outside a write state")
    `RSBM_ASSERT_NXT(a_full_keeps, clk, rst_n, (state_reg == rsbm_pkg::ST_DONE) && (status_reg != rsbm_pkg::STATUS_OK), count_reg == $past(count_reg), "flagged beat changed the count")

endmodule

### tb/sv/testbench.sv
// self-checking testbench for range_state_boundary_map_top
// depends on rsbm_pkg and the rtl of range_state_boundary_map_top
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NBND = 64;
    localparam int PHASE_ITEMS = 225;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    rsbm_pkg::req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsbm_pkg::rsp_t rsp;

    range_state_boundary_map_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // shadow copy of the boundary table
    logic [47:0] map_addr [NBND];
    logic [15:0] map_in [NBND];
    logic [15:0] map_out [NBND];
    int unsigned map_count;

    rsbm_pkg::rsp_t expected_rsp_q[$];
    int unsigned mismatch_count;
    int unsigned send_idle_pct;
    int unsigned stall_pct;

    // directed rows: check_row set means the response is typed in
    typedef struct packed {
        rsbm_pkg::req_t rq;
        bit             check_row;
        rsbm_pkg::rsp_t rs;
    } row_t;

    function automatic rsbm_pkg::req_t mk_paint(logic [47:0] a, logic [47:0] b,
        logic [15:0] s);
        rsbm_pkg::req_t r;
        r.operation = rsbm_pkg::OP_PAINT;
        r.range_start = a;
        r.range_end = b;
        r.new_state = s;
        r.entry_index = '0;
        return r;
    endfunction

    function automatic rsbm_pkg::req_t mk_read(logic [5:0] i);
        rsbm_pkg::req_t r;
        r.operation = rsbm_pkg::OP_READ;
        r.range_start = {48{i[0]}};
        r.range_end = {48{i[1]}};
        r.new_state = {16{i[2]}};
        r.entry_index = i;
        return r;
    endfunction

    function automatic rsbm_pkg::rsp_t mk_rsp(rsbm_pkg::status_t st, int unsigned cnt);
        rsbm_pkg::rsp_t r;
        r = '0;
        r.status = st;
        r.boundary_count = cnt[6:0];
        return r;
    endfunction

    // builds the painted table in a scratch copy, commits when it fits
    function automatic rsbm_pkg::status_t paint_map(logic [47:0] a, logic [47:0] b,
        logic [15:0] s);
        logic [47:0] na [NBND+2];
        logic [15:0] ni [NBND+2];
        logic [15:0] no [NBND+2];
        int unsigned k;
        logic [15:0] a_in;
        logic [15:0] b_out;
        k = 0;
        a_in = '0;
        b_out = '0;
        if (b <= a)
            return rsbm_pkg::STATUS_EMPTY;
        for (int i = 0; i < map_count; i++)
        begin
            if (map_addr[i] < a)
            begin
                if (k < NBND + 2)
                begin
                    na[k] = map_addr[i];
                    ni[k] = map_in[i];
                    no[k] = map_out[i];
                end
                k++;
                a_in = map_out[i];
                b_out = map_out[i];
            end
            else if (map_addr[i] == a)
            begin
                a_in = map_in[i];
                b_out = map_out[i];
            end
            else if (map_addr[i] <= b)
                b_out = map_out[i];
        end
        if (a_in != s)
        begin
            if (k < NBND + 2)
            begin
                na[k] = a;
                ni[k] = a_in;
                no[k] = s;
            end
            k++;
        end
        if (b_out != s)
        begin
            if (k < NBND + 2)
            begin
                na[k] = b;
                ni[k] = s;
                no[k] = b_out;
            end
            k++;
        end
        for (int i = 0; i < map_count; i++)
        begin
            if (map_addr[i] > b)
            begin
                if (k < NBND + 2)
                begin
                    na[k] = map_addr[i];
                    ni[k] = map_in[i];
                    no[k] = map_out[i];
                end
                k++;
            end
        end
        if (k > NBND)
            return rsbm_pkg::STATUS_FULL;
        for (int i = 0; i < k; i++)
        begin
            map_addr[i] = na[i];
            map_in[i] = ni[i];
            map_out[i] = no[i];
        end
        map_count = k;
        return rsbm_pkg::STATUS_OK;
    endfunction

    function automatic rsbm_pkg::rsp_t predict_map_rsp(rsbm_pkg::req_t r);
        rsbm_pkg::rsp_t e;
        e = '0;
        if (r.operation == rsbm_pkg::OP_PAINT)
            e.status = paint_map(r.range_start, r.range_end, r.new_state);
        else if (r.entry_index >= map_count)
            e.status = rsbm_pkg::STATUS_BAD_INDEX;
        else
        begin
            e.status = rsbm_pkg::STATUS_OK;
            e.entry_address = map_addr[r.entry_index];
            e.entry_state_in = map_in[r.entry_index];
            e.entry_state_out = map_out[r.entry_index];
        end
        e.boundary_count = map_count[6:0];
        return e;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        mismatch_count++;
    endtask

    // drive one beat at the falling edge and hold until accepted
    task automatic send_beat(rsbm_pkg::req_t r);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            req <= rsbm_pkg::req_t'($urandom());
            @(negedge clk);
        end
        req <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_checked(rsbm_pkg::req_t r);
        expected_rsp_q.push_back(predict_map_rsp(r));
        send_beat(r);
    endtask

    always @(negedge clk)
    begin
        if (stall_pct != 0 && $urandom_range(99) < stall_pct)
            rsp_stall <= 1'b1;
        else
            rsp_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        rsbm_pkg::rsp_t e;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp_q.size() == 0)
            begin
                $display("unexpected response beat at %0t", $realtime);
                mismatch_count++;
            end
            else
            begin
                e = expected_rsp_q.pop_front();
                if (rsp.status !== e.status)
                    report_mismatch("status", rsp.status, e.status);
                if (rsp.boundary_count !== e.boundary_count)
                    report_mismatch("boundary_count", rsp.boundary_count, e.boundary_count);
                if (rsp.entry_address !== e.entry_address)
                    report_mismatch("entry_address", rsp.entry_address, e.entry_address);
                if (rsp.entry_state_in !== e.entry_state_in)
                    report_mismatch("entry_state_in", rsp.entry_state_in, e.entry_state_in);
                if (rsp.entry_state_out !== e.entry_state_out)
                    report_mismatch("entry_state_out", rsp.entry_state_out,
                        e.entry_state_out);
            end
        end
    end

    function automatic logic [47:0] rand_addr(int unsigned mode);
        logic [47:0] v;
        case (mode)
            0: v = 48'($urandom_range(255));
            1: v = 48'hFFFF_FFFF_FF00 | 48'($urandom_range(255));
            default: v = 48'({$urandom(), $urandom()});
        endcase
        return v;
    endfunction

    function automatic logic [15:0] rand_state();
        int unsigned m;
        m = $urandom_range(9);
        if (m < 3)
            return '0;
        else if (m < 7)
            return 16'($urandom_range(4));
        return 16'($urandom());
    endfunction

    task automatic random_phase(int unsigned n);
        rsbm_pkg::req_t r;
        logic [47:0] x;
        logic [47:0] y;
        int unsigned mode;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(2) == 0)
                r = mk_read(6'($urandom_range(map_count + 2 > 63 ? 63 : map_count + 2)));
            else
            begin
                mode = ($urandom_range(19) == 0) ? 2 : $urandom_range(1);
                x = rand_addr(mode);
                y = rand_addr(mode);
                if ($urandom_range(15) != 0 && x > y)
                    r = mk_paint(y, x, rand_state());
                else
                    r = mk_paint(x, y, rand_state());
            end
            send_checked(r);
        end
    endtask

    row_t rows[$];

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        req = '0;
        rsp_stall = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        map_count = 0;
        mismatch_count = 0;

        rows.push_back('{mk_read(6'd0), 1'b1, mk_rsp(rsbm_pkg::STATUS_BAD_INDEX, 0)});
        rows.push_back('{mk_read(6'd63), 1'b1, mk_rsp(rsbm_pkg::STATUS_BAD_INDEX, 0)});
        rows.push_back('{mk_paint(48'd5, 48'd5, 16'h1), 1'b1,
            mk_rsp(rsbm_pkg::STATUS_EMPTY, 0)});
        rows.push_back('{mk_paint(48'hFFFF_FFFF_FFFF, 48'd0, 16'hFFFF), 1'b1,
            mk_rsp(rsbm_pkg::STATUS_EMPTY, 0)});
        rows.push_back('{mk_paint(48'd0, 48'hFFFF_FFFF_FFFF, 16'hFFFF), 1'b1,
            mk_rsp(rsbm_pkg::STATUS_OK, 2)});
        rows.push_back('{mk_read(6'd0), 1'b0, '0});
        rows.push_back('{mk_read(6'd1), 1'b0, '0});
        rows.push_back('{mk_read(6'd2), 1'b1, mk_rsp(rsbm_pkg::STATUS_BAD_INDEX, 2)});
        // paint inside, then same state over it merges back
        rows.push_back('{mk_paint(48'h100, 48'h200, 16'h0101), 1'b0, '0});
        rows.push_back('{mk_paint(48'h100, 48'h200, 16'hFFFF), 1'b0, '0});
        // unmap everything leaves no boundary
        rows.push_back('{mk_paint(48'd0, 48'hFFFF_FFFF_FFFF, 16'h0), 1'b1,
            mk_rsp(rsbm_pkg::STATUS_OK, 0)});
        rows.push_back('{mk_paint(48'h10, 48'h20, 16'h0001), 1'b0, '0});
        rows.push_back('{mk_paint(48'h20, 48'h30, 16'h0002), 1'b0, '0});
        rows.push_back('{mk_paint(48'h18, 48'h28, 16'h0003), 1'b0, '0});
        rows.push_back('{mk_paint(48'h0, 48'h40, 16'h0001), 1'b0, '0});
        rows.push_back('{mk_read(6'd1), 1'b0, '0});
        rows.push_back('{mk_paint(48'h0, 48'h40, 16'h0), 1'b0, '0});

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (rows[i])
        begin
            rsbm_pkg::rsp_t p;
            p = predict_map_rsp(rows[i].rq);
            expected_rsp_q.push_back(rows[i].check_row ? rows[i].rs : p);
            send_beat(rows[i].rq);
        end
        // fill to capacity with disjoint ranges, then overflow
        for (int i = 0; i < 33; i++)
            send_checked(mk_paint(48'(i * 4 + 1), 48'(i * 4 + 3), 16'(i + 1)));
        send_checked(mk_read(6'd63));
        send_checked(mk_paint(48'h0, 48'hFFFF_FFFF_FFFF, 16'h0));

        random_phase(PHASE_ITEMS);
        send_idle_pct = 82;
        random_phase(PHASE_ITEMS);
        send_idle_pct = 0;
        stall_pct = 82;
        random_phase(PHASE_ITEMS);
        send_idle_pct = 30;
        stall_pct = 30;
        random_phase(PHASE_ITEMS);
        req_valid <= 1'b0;

        while (expected_rsp_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (mismatch_count == 0 && expected_rsp_q.size() == 0)
            $display("range_state_boundary_map_top regression: pass");
        else
            $display("range_state_boundary_map_top regression: fail");
        $finish;
    end

    initial
    begin
        #40ms;
        $display("range_state_boundary_map_top regression: fail");
        $finish;
    end
endmodule

### range_state_boundary_map_top.f
+incdir+hw/rtl
hw/rtl/rsbm_pkg.sv
hw/rtl/rsbm_ram.sv
hw/rtl/range_state_boundary_map_top.sv
tb/sv/testbench.sv
